[sv/mt64_pkg.sv]
package mt64_pkg;

  localparam int unsigned Words = 312;
  localparam int unsigned Mid   = 156;
  localparam int unsigned AddrW = $clog2(Words);

  localparam logic [63:0] Matrix  = 64'hb502_6f5a_a966_19e9;
  localparam logic [63:0] TempD   = 64'h5555_5555_5555_5555;
  localparam logic [63:0] TempB   = 64'h71d6_7fff_eda6_0000;
  localparam logic [63:0] TempC   = 64'hfff7_eee0_0000_0000;
  localparam logic [63:0] SeedMul = 64'd6364136223846793005;

  localparam int unsigned ShU = 29;
  localparam int unsigned ShS = 17;
  localparam int unsigned ShT = 37;
  localparam int unsigned ShL = 43;

  // split point of the twist mix: upper part from word k, lower 31 bits from word k+1
  localparam int unsigned LowBits = 31;

  typedef struct packed {
    logic        cmd;
    logic [63:0] seed_value;
  } mt64_in_t;

  typedef struct packed {
    logic [63:0] random_value;
    logic        not_seeded;
  } mt64_out_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [63:0]      data;
  } mt64_wr_t;

  localparam logic CmdSeed = 1'b0;
  localparam logic CmdDraw = 1'b1;

endpackage

[sv/mersenne_twister_64_core.sv]
// draw: result strobe after the states FAR and TW and the result register, next start taken in that
// same cycle; the two memory read turns (word k with k+1, then word k+156) precede the write back.
// draw before any seed: result strobe in the cycle after start with zero value and not_seeded set.
// reseed: no result, busy while words 1 to 311 each pass MIX, MUL0, MUL1, MUL2 and SUM on one
// shared 32x32 multiplier. reset leaves the block unseeded; the word memory is not cleared.
module mersenne_twister_64_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  mt64_pkg::mt64_in_t    in_i,
  output logic                  result_valid_o,
  output mt64_pkg::mt64_out_t   result_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FAR  = 3'b010,
    ST_TW   = 3'b100
  } state_e;

  localparam int unsigned AW = mt64_pkg::AddrW;
  localparam logic [AW-1:0] LastIdx = AW'(mt64_pkg::Words - 1);
  localparam logic [AW-1:0] MidIdx  = AW'(mt64_pkg::Mid);

  function automatic logic [63:0] temper(input logic [63:0] w);
    logic [63:0] y;
    y = w;
    y = y ^ ((y >> mt64_pkg::ShU) & mt64_pkg::TempD);
    y = y ^ ((y << mt64_pkg::ShS) & mt64_pkg::TempB);
    y = y ^ ((y << mt64_pkg::ShT) & mt64_pkg::TempC);
    y = y ^ (y >> mt64_pkg::ShL);
    return y;
  endfunction

  state_e                 state_q, state_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic                   seeded_q, seeded_d;
  logic                   res_valid_q, res_valid_d;
  mt64_pkg::mt64_out_t    res_q, res_d;
  logic [63:0]            mix_q, mix_d;

  logic [63:0]            mem [mt64_pkg::Words];
  logic [63:0]            rd_a_q, rd_b_q;
  logic [AW-1:0]          addr_a, addr_b;
  logic [AW-1:0]          pos_next, pos_far;
  logic [63:0]            shifted, tw_word;
  mt64_pkg::mt64_wr_t     sg_wr, tw_wr, wr;
  logic                   sg_busy;
  logic                   accept;

  assign busy   = (state_q != ST_IDLE) || sg_busy;
  assign accept = start && !busy;

  mt64_seed_gen u_seed_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept && (in_i.cmd == mt64_pkg::CmdSeed)),
    .seed_i (in_i.seed_value),
    .busy_o (sg_busy),
    .wr_o   (sg_wr)
  );

  assign pos_next = (pos_q == LastIdx) ? '0 : pos_q + 1'b1;
  assign pos_far  = (pos_q < MidIdx) ? pos_q + MidIdx : pos_q - MidIdx;

  assign addr_a = (state_q == ST_FAR) ? pos_far : pos_q;
  assign addr_b = pos_next;

  // word k is twisted in place just before it is tempered; this matches a full twist
  // since word k+1 is still old and word k+156 is new exactly when the full pass has it so
  assign shifted = (mix_q >> 1) ^ (mix_q[0] ? mt64_pkg::Matrix : 64'd0);
  assign tw_word = rd_a_q ^ shifted;

  always_comb begin
    tw_wr      = '0;
    tw_wr.we   = (state_q == ST_TW);
    tw_wr.addr = pos_q;
    tw_wr.data = tw_word;
    wr         = sg_wr.we ? sg_wr : tw_wr;
  end

  always_ff @(posedge clk_i) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    seeded_d    = seeded_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mix_d       = mix_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.cmd == mt64_pkg::CmdSeed) begin
            seeded_d = 1'b1;
            pos_d    = '0;
          end else if (seeded_q) begin
            state_d = ST_FAR;
          end else begin
            res_valid_d           = 1'b1;
            res_d.random_value    = '0;
            res_d.not_seeded      = 1'b1;
          end
        end
      end
      ST_FAR: begin
        mix_d   = {rd_a_q[63:mt64_pkg::LowBits], rd_b_q[mt64_pkg::LowBits-1:0]};
        state_d = ST_TW;
      end
      ST_TW: begin
        res_valid_d        = 1'b1;
        res_d.random_value = temper(tw_word);
        res_d.not_seeded   = 1'b0;
        pos_d              = pos_next;
        state_d            = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      seeded_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      seeded_q    <= seeded_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    mix_q <= mix_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_seed_draw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sg_busy && (state_q != ST_IDLE)))
    else $error("seeding and drawing overlap");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> (wr.addr <= LastIdx))
    else $error("memory write beyond last word");

  a_draw_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.cmd == mt64_pkg::CmdDraw) && seeded_q) |-> ##3 result_valid_o)
    else $error("seeded draw gave no result after three cycles");

  a_unseeded_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.cmd == mt64_pkg::CmdDraw) && !seeded_q)
      |=> (result_valid_o && result_o.not_seeded && (result_o.random_value == 64'd0)))
    else $error("unseeded draw result wrong");

endmodule

[sv/mt64_seed_gen.sv]
module mt64_seed_gen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [63:0]          seed_i,
  output logic                 busy_o,
  output mt64_pkg::mt64_wr_t   wr_o
);

  typedef enum logic [5:0] {
    SG_IDLE = 6'b000001,
    SG_MIX  = 6'b000010,
    SG_MUL0 = 6'b000100,
    SG_MUL1 = 6'b001000,
    SG_MUL2 = 6'b010000,
    SG_SUM  = 6'b100000
  } sg_state_e;

  localparam logic [mt64_pkg::AddrW-1:0] LastIdx = mt64_pkg::AddrW'(mt64_pkg::Words - 1);

  sg_state_e                   state_q, state_d;
  logic [mt64_pkg::AddrW-1:0]  k_q, k_d;
  logic [63:0]                 prev_q, prev_d;
  logic [63:0]                 x_q, x_d;
  logic [63:0]                 p0_q, p0_d;
  logic [31:0]                 acc_q, acc_d;
  logic [31:0]                 mul_a, mul_b;
  logic [63:0]                 mul_p;
  logic [63:0]                 sum_word;

  // one shared 32x32 multiplier, three passes give the low 64 bits of x * SeedMul
  always_comb begin
    mul_a = x_q[31:0];
    mul_b = mt64_pkg::SeedMul[31:0];
    case (state_q)
      SG_MUL1: begin
        mul_a = x_q[63:32];
        mul_b = mt64_pkg::SeedMul[31:0];
      end
      SG_MUL2: begin
        mul_a = x_q[31:0];
        mul_b = mt64_pkg::SeedMul[63:32];
      end
      default: begin
        mul_a = x_q[31:0];
        mul_b = mt64_pkg::SeedMul[31:0];
      end
    endcase
  end

  assign mul_p    = 64'(mul_a) * 64'(mul_b);
  assign sum_word = p0_q + {acc_q, 32'd0} + 64'(k_q);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    prev_d  = prev_q;
    x_d     = x_q;
    p0_d    = p0_q;
    acc_d   = acc_q;
    wr_o    = '0;
    case (state_q)
      SG_IDLE: begin
        if (start_i) begin
          wr_o.we   = 1'b1;
          wr_o.addr = '0;
          wr_o.data = seed_i;
          prev_d    = seed_i;
          k_d       = mt64_pkg::AddrW'(1);
          state_d   = SG_MIX;
        end
      end
      SG_MIX: begin
        x_d     = prev_q ^ (prev_q >> 62);
        state_d = SG_MUL0;
      end
      SG_MUL0: begin
        p0_d    = mul_p;
        state_d = SG_MUL1;
      end
      SG_MUL1: begin
        acc_d   = mul_p[31:0];
        state_d = SG_MUL2;
      end
      SG_MUL2: begin
        acc_d   = acc_q + mul_p[31:0];
        state_d = SG_SUM;
      end
      SG_SUM: begin
        wr_o.we   = 1'b1;
        wr_o.addr = k_q;
        wr_o.data = sum_word;
        prev_d    = sum_word;
        if (k_q == LastIdx) begin
          state_d = SG_IDLE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = SG_MIX;
        end
      end
      default: begin
        state_d = SG_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != SG_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SG_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    x_q    <= x_d;
    p0_q   <= p0_d;
    acc_q  <= acc_d;
  end

endmodule
